>>> rtl/obl_pkg.sv
`default_nettype none
package obl_pkg;

  // output fraction bits
  localparam int RESULT_FRAC_BITS = 16;

  // path exponent bits, Q.28 below 64.0
  localparam int X_BITS = 34;

  // quotient bits retired per divider stage
  localparam int DIV_STEP = 2;
  localparam int DIV_STAGES = X_BITS / DIV_STEP;

  // exp series terms
  localparam int HORNER_STEPS = 12;

  // exp unit: two multiply stages, one ln2 stage, three per term, one shift stage
  localparam int EXP_LAT = 3 + 3 * HORNER_STEPS + 1;

  // start to done: depth, setup, divider, exponent select, exp unit, output
  localparam int TOTAL_LAT = 2 + DIV_STAGES + 1 + EXP_LAT + 1;

  localparam logic [29:0] LOG2E_Q29 = 30'd774541002;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // floor(2^32 / k), indexed by k
  localparam logic [32:0] RECIP [0:12] = '{
    33'd0,
    33'd4294967296,
    33'd2147483648,
    33'd1431655765,
    33'd1073741824,
    33'd858993459,
    33'd715827882,
    33'd613566756,
    33'd536870912,
    33'd477218588,
    33'd429496729,
    33'd390451572,
    33'd357913941
  };

  typedef struct packed {
    logic [15:0] ozone_column;
    logic [15:0] absorption_coeff;
    logic [15:0] solar_cos_zenith;
    logic [15:0] sensor_cos_zenith;
  } item_t;

  typedef struct packed {
    logic [15:0] solar_transmittance;
    logic [15:0] sensor_transmittance;
    logic [15:0] combined_transmittance;
  } result_t;

  typedef struct packed {
    logic [X_BITS-1:0] x;
    logic              zero;
  } exp_in_t;

endpackage
`default_nettype wire

>>> rtl/obl_exp.sv
`default_nettype none
module obl_exp (
  input  wire logic            clk,
  input  obl_pkg::exp_in_t     x_in,
  output logic [15:0]          y
);
  import obl_pkg::*;

  // multiply by log2(e), split in halves
  logic [46:0] pl;
  logic [46:0] ph;
  logic        z1;

  always_ff @(posedge clk) begin
    pl <= 47'(x_in.x[16:0]) * 47'(LOG2E_Q29);
    ph <= 47'(x_in.x[X_BITS-1:17]) * 47'(LOG2E_Q29);
    z1 <= x_in.zero;
  end

  // integer and fraction of the base-2 exponent
  logic [63:0] ysum;
  logic [6:0]  n2;
  logic [27:0] f2;
  logic        z2;

  assign ysum = {ph[46:0], 17'b0} + 64'(pl);

  always_ff @(posedge clk) begin
    n2 <= ysum[63:57];
    f2 <= ysum[56:29];
    z2 <= z1;
  end

  // fraction times ln2
  logic [59:0] tprod;
  assign tprod = 60'(f2) * 60'(LN2_Q32);

  logic [32:0] hr [0:HORNER_STEPS];
  logic [31:0] ht [0:HORNER_STEPS];
  logic [6:0]  hn [0:HORNER_STEPS];
  logic        hz [0:HORNER_STEPS];

  always_ff @(posedge clk) begin
    hr[0] <= ONE_Q32;
    ht[0] <= tprod[59:28];
    hn[0] <= n2;
    hz[0] <= z2;
  end

  // series terms, three stages each
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_term
    localparam int K = HORNER_STEPS - i;

    logic [31:0] ap;
    logic [31:0] at;
    logic [6:0]  an;
    logic        az;
    logic [64:0] aprod;

    assign aprod = 65'(ht[i]) * 65'(hr[i]);

    always_ff @(posedge clk) begin
      ap <= aprod[63:32];
      at <= ht[i];
      an <= hn[i];
      az <= hz[i];
    end

    // reciprocal estimate of the quotient
    logic [31:0] bq;
    logic [31:0] bp;
    logic [31:0] bt;
    logic [6:0]  bn;
    logic        bz;
    logic [64:0] bprod;

    assign bprod = 65'(ap) * 65'(RECIP[K]);

    always_ff @(posedge clk) begin
      bq <= bprod[63:32];
      bp <= ap;
      bt <= at;
      bn <= an;
      bz <= az;
    end

    // correct the estimate by one and form the next term
    logic [35:0] cqk;
    logic [35:0] crem;
    logic [32:0] cq;

    always_comb begin
      cqk  = 36'(bq) * 36'(K);
      crem = 36'(bp) - cqk;
      cq   = (crem >= 36'(K)) ? 33'(bq) + 33'd1 : 33'(bq);
    end

    always_ff @(posedge clk) begin
      hr[i+1] <= ONE_Q32 - cq;
      ht[i+1] <= bt;
      hn[i+1] <= bn;
      hz[i+1] <= bz;
    end
  end

  // scale by 2^-n with rounding, saturate
  logic [7:0]  s;
  logic [63:0] rnd;
  logic [63:0] v;

  always_comb begin
    s   = 8'(32 - RESULT_FRAC_BITS) + {1'b0, hn[HORNER_STEPS]};
    rnd = 64'd0;
    v   = 64'd0;
    if (s >= 8'd64) begin
      v = 64'd0;
    end else if (s == 8'd0) begin
      v = 64'(hr[HORNER_STEPS]);
    end else begin
      rnd = 64'd1 << (s[5:0] - 6'd1);
      v   = (64'(hr[HORNER_STEPS]) + rnd) >> s[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (hz[HORNER_STEPS]) begin
      y <= 16'd0;
    end else if (v > 64'd65535) begin
      y <= 16'hFFFF;
    end else begin
      y <= v[15:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/ozone_beer_lambert_transmittance.sv
// channel   ports                      handshake
// request   start, busy, item          taken when start and not busy
// result    done, result               one cycle per result, no back-pressure
// config    cfg_we, cfg_wdata          written when cfg_we
//
// one request per cycle while busy is low
// latency comes mostly from the 17-stage radix-4 divider and the 12-term exp series,
// three stages a term
// busy is high only during reset; reset clears the valid line and the mode
// the pipeline never stalls since the receiver always takes results
`default_nettype none
module ozone_beer_lambert_transmittance (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  obl_pkg::item_t         item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  output logic                   done,
  output obl_pkg::result_t       result
);
  import obl_pkg::*;

  logic combined_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      combined_mode <= 1'b0;
    end else if (cfg_we) begin
      combined_mode <= cfg_wdata;
    end
  end

  assign busy = rst;

  // optical depth
  logic        v1;
  logic        m1;
  logic [31:0] depth1;
  logic [15:0] cs1;
  logic [15:0] cn1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    m1     <= combined_mode;
    depth1 <= 32'(item.ozone_column) * 32'(item.absorption_coeff);
    cs1    <= item.solar_cos_zenith;
    cn1    <= item.sensor_cos_zenith;
  end

  // divider pipeline, lane 0 solar, lane 1 sensor
  logic              dv    [0:DIV_STAGES];
  logic              dm    [0:DIV_STAGES];
  logic [31:0]       ddep  [0:DIV_STAGES];
  logic [15:0]       ddiv  [0:1][0:DIV_STAGES];
  logic [15:0]       drem  [0:1][0:DIV_STAGES];
  logic [X_BITS-1:0] dq    [0:1][0:DIV_STAGES];
  logic              dz    [0:1][0:DIV_STAGES];

  // setup: zero and overflow checks, first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v1;
    end
    dm[0]      <= m1;
    ddep[0]    <= depth1;
    ddiv[0][0] <= cs1;
    ddiv[1][0] <= cn1;
    drem[0][0] <= {2'b0, depth1[31:18]};
    drem[1][0] <= {2'b0, depth1[31:18]};
    dq[0][0]   <= '0;
    dq[1][0]   <= '0;
    dz[0][0]   <= (cs1 == 16'd0) || ({2'b0, depth1} >= {cs1, 18'b0});
    dz[1][0]   <= (cn1 == 16'd0) || ({2'b0, depth1} >= {cn1, 18'b0});
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else begin
        dv[j+1] <= dv[j];
      end
      dm[j+1]   <= dm[j];
      ddep[j+1] <= ddep[j];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [47:0]       dfull;
      logic [15:0]       rm;
      logic [X_BITS-1:0] qq;
      logic [16:0]       trial;

      // restoring steps, DIV_STEP quotient bits
      always_comb begin
        dfull = {ddep[j], 16'b0};
        rm    = drem[l][j];
        qq    = dq[l][j];
        trial = '0;
        for (int u = 0; u < DIV_STEP; u++) begin
          trial = {rm, dfull[X_BITS - 1 - DIV_STEP * j - u]};
          if (trial >= {1'b0, ddiv[l][j]}) begin
            rm = 16'(trial - {1'b0, ddiv[l][j]});
            qq = {qq[X_BITS-2:0], 1'b1};
          end else begin
            rm = trial[15:0];
            qq = {qq[X_BITS-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        ddiv[l][j+1] <= ddiv[l][j];
        drem[l][j+1] <= rm;
        dq[l][j+1]   <= qq;
        dz[l][j+1]   <= dz[l][j];
      end
    end
  end

  // exponent select: second unit takes the sensor or the combined path
  logic [X_BITS:0] xsum;
  exp_in_t         ein [0:1];
  logic            ev  [0:EXP_LAT];
  logic            em  [0:EXP_LAT];

  assign xsum = {1'b0, dq[0][DIV_STAGES]} + {1'b0, dq[1][DIV_STAGES]};

  always_ff @(posedge clk) begin
    if (rst) begin
      ev[0] <= 1'b0;
    end else begin
      ev[0] <= dv[DIV_STAGES];
    end
    em[0]       <= dm[DIV_STAGES];
    ein[0].x    <= dq[0][DIV_STAGES];
    ein[0].zero <= dz[0][DIV_STAGES];
    if (dm[DIV_STAGES]) begin
      ein[1].x    <= xsum[X_BITS-1:0];
      ein[1].zero <= dz[0][DIV_STAGES] || dz[1][DIV_STAGES] || xsum[X_BITS];
    end else begin
      ein[1].x    <= dq[1][DIV_STAGES];
      ein[1].zero <= dz[1][DIV_STAGES];
    end
  end

  // valid and mode ride alongside the exp units
  for (genvar e = 0; e < EXP_LAT; e++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        ev[e+1] <= 1'b0;
      end else begin
        ev[e+1] <= ev[e];
      end
      em[e+1] <= em[e];
    end
  end

  logic [15:0] tsol;
  logic [15:0] tpath;

  obl_exp u_exp_solar (
    .clk  (clk),
    .x_in (ein[0]),
    .y    (tsol)
  );

  obl_exp u_exp_path (
    .clk  (clk),
    .x_in (ein[1]),
    .y    (tpath)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ev[EXP_LAT];
    end
    result.solar_transmittance    <= tsol;
    result.sensor_transmittance   <= em[EXP_LAT] ? 16'd0 : tpath;
    result.combined_transmittance <= em[EXP_LAT] ? tpath : 16'd0;
  end

endmodule
`default_nettype wire

>>> rtl/obl_chk.sv
`default_nettype none
module obl_chk (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input obl_pkg::item_t         item,
  input wire logic              done,
  input obl_pkg::result_t       result
);
  import obl_pkg::*;

  // busy follows reset and nothing else
  a_no_busy: assert property (@(posedge clk) busy == rst)
    else $error("busy outside reset");

  // every request gives a result after the fixed latency
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##TOTAL_LAT done)
    else $error("result missing after request");

  // no result without a request
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without request");

  // only one of the second-path fields is in use
  a_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.sensor_transmittance == 16'd0 ||
              result.combined_transmittance == 16'd0))
    else $error("sensor and combined both set");

  // zero solar cosine gives zero solar transmittance
  a_zero_cos: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.solar_cos_zenith == 16'd0) |->
      ##TOTAL_LAT (result.solar_transmittance == 16'd0))
    else $error("zero solar cosine gave nonzero result");

endmodule

bind ozone_beer_lambert_transmittance obl_chk u_obl_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire
